### rtl/tce_pkg.sv
// Shared types, codes and constants of the text console engine.
package tce_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	localparam int ROW_W = 5;
	localparam int COL_W = 7;

	localparam int CQ_DEPTH = 2;

	localparam logic [7:0] CH_NEWLINE          = 8'd10;
	localparam logic [7:0] CH_BACKSPACE        = 8'd8;
	localparam logic [7:0] CH_SPACE            = 8'd32;
	localparam logic [7:0] ATTR_WHITE_ON_BLACK = 8'd15;
	localparam logic [7:0] ATTR_RESET          = 8'd15;

	typedef enum logic [1:0] {
		MODE_PUT    = 2'd0,
		MODE_SETCUR = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_SETCUR,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL
	} be_state_t;

endpackage

### rtl/tce_front.sv
// Front end: decode an input beat into a console command with clamped cell coordinates.
module tce_front import tce_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic             accept_en,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [7:0]       char_code,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] col,
	output logic             q_valid,
	input  logic             q_ready,
	output cmd_t             q_cmd
);

	logic [ROW_W-1:0] row_sat;
	logic [COL_W-1:0] col_sat;

	assign in_ready = accept_en & q_ready;
	assign q_valid  = accept_en & in_valid;

	// Clamp the target cell to the screen.
	always_comb begin
		if (int'(row) > ROWS - 1) begin
			row_sat = ROW_W'(ROWS - 1);
		end else begin
			row_sat = row;
		end
		if (int'(col) > COLS - 1) begin
			col_sat = COL_W'(COLS - 1);
		end else begin
			col_sat = col;
		end
	end

	always_comb begin
		q_cmd.ch  = char_code;
		q_cmd.row = row_sat;
		q_cmd.col = col_sat;
		unique case (mode_t'(mode))
			MODE_PUT: begin
				case (char_code)
					CH_NEWLINE:   q_cmd.op = OP_NEWLINE;
					CH_BACKSPACE: q_cmd.op = OP_BACKSPACE;
					default:      q_cmd.op = OP_PUT;
				endcase
			end
			MODE_SETCUR: q_cmd.op = OP_SETCUR;
			MODE_CLEAR:  q_cmd.op = OP_CLEAR;
			MODE_READ:   q_cmd.op = OP_READ;
			default:     q_cmd.op = OP_PUT;
		endcase
	end

endmodule

### rtl/tce_cmd_fifo.sv
// Short command queue between the front end and the execution back end.
module tce_cmd_fifo import tce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int NW = $clog2(CQ_DEPTH + 1);

	cmd_t          slots_q [CQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != NW'(CQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/tce_back.sv
// Back end: cursor, ring-addressed screen memory, scroll and fill sweeps, result register.
module tce_back import tce_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	input  logic [7:0]       char_attr,
	output logic             init_done,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ROW_W-1:0] res_row,
	output logic [COL_W-1:0] res_col,
	output logic [7:0]       res_char,
	output logic [7:0]       res_attr,
	output logic             res_scrolled
);

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLS);

	be_state_t     state_q, state_d;
	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] top_q, top_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic          out_valid_q;
	logic          out_free;
	logic          load_out;
	logic [7:0]    res_char_d, res_attr_d;
	logic          res_scr_d;

	logic [ROW_W-1:0] res_row_q;
	logic [COL_W-1:0] res_col_q;
	logic [7:0]       res_char_q, res_attr_q;
	logic             res_scr_q;

	logic [15:0]   screen_q [NCELLS];
	logic [15:0]   rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata;

	logic          last_col, last_row;
	logic [RW-1:0] top_inc;
	logic [RW-1:0] bs_row;
	logic [CW-1:0] bs_col;

	// Map a logical row through the top-row offset to a physical cell address.
	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
			input logic [RW-1:0] t, input logic [CW-1:0] c);
		logic [RW:0]   s;
		logic [RW-1:0] pr;
		s = {1'b0, r} + {1'b0, t};
		if (s >= (RW+1)'(ROWS)) begin
			pr = RW'(s - (RW+1)'(ROWS));
		end else begin
			pr = RW'(s);
		end
		return AW'(AW'(pr) * AW'(COLS) + AW'(c));
	endfunction

	assign last_col = (col_q == CW'(COLS - 1));
	assign last_row = (row_q == RW'(ROWS - 1));
	assign top_inc  = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
	assign out_free = !out_valid_q || out_ready;
	assign init_done = (state_q != ST_INIT);

	// Step back one cell, wrapping to the end of the previous row; hold at top left.
	always_comb begin
		if (col_q != '0) begin
			bs_row = row_q;
			bs_col = col_q - CW'(1);
		end else if (row_q != '0) begin
			bs_row = row_q - RW'(1);
			bs_col = CW'(COLS - 1);
		end else begin
			bs_row = '0;
			bs_col = '0;
		end
	end

	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		top_d      = top_q;
		sweep_d    = sweep_q;
		cmd_ready  = 1'b0;
		load_out   = 1'b0;
		res_char_d = '0;
		res_attr_d = '0;
		res_scr_d  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = cell_addr(row_q, top_q, col_q);
		mem_wdata  = '0;
		mem_raddr  = cell_addr(RW'(cmd.row), top_q, CW'(cmd.col));
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				if (sweep_q == AW'(NCELLS - 1)) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_ready = 1'b1;
					unique case (cmd.op)
						OP_PUT, OP_NEWLINE: begin
							if (cmd.op == OP_PUT) begin
								mem_we    = 1'b1;
								mem_wdata = {char_attr, cmd.ch};
							end
							if (cmd.op == OP_PUT && !last_col) begin
								col_d    = col_q + CW'(1);
								load_out = 1'b1;
							end else if (last_row) begin
								col_d   = '0;
								top_d   = top_inc;
								state_d = ST_SCROLL;
							end else begin
								col_d    = '0;
								row_d    = row_q + RW'(1);
								load_out = 1'b1;
							end
						end
						OP_BACKSPACE: begin
							row_d     = bs_row;
							col_d     = bs_col;
							mem_we    = 1'b1;
							mem_waddr = cell_addr(bs_row, top_q, bs_col);
							mem_wdata = {char_attr, CH_SPACE};
							load_out  = 1'b1;
						end
						OP_SETCUR: begin
							row_d    = RW'(cmd.row);
							col_d    = CW'(cmd.col);
							load_out = 1'b1;
						end
						OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							top_d   = '0;
							state_d = ST_FILL;
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				load_out   = 1'b1;
				res_char_d = rdata_q[7:0];
				res_attr_d = rdata_q[15:8];
				state_d    = ST_IDLE;
			end
			ST_SCROLL: begin
				// Blank the row that wrapped around to the bottom of the screen.
				mem_we    = 1'b1;
				mem_waddr = cell_addr(RW'(ROWS - 1), top_q, CW'(sweep_q));
				if (sweep_q == AW'(COLS - 1)) begin
					sweep_d   = '0;
					load_out  = 1'b1;
					res_scr_d = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					sweep_d = sweep_q + AW'(1);
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = {ATTR_WHITE_ON_BLACK, CH_SPACE};
				if (sweep_q == AW'(NCELLS - 1)) begin
					sweep_d  = '0;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					sweep_d = sweep_q + AW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			top_q       <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			top_q   <= top_d;
			sweep_q <= sweep_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_row_q  <= ROW_W'(row_d);
			res_col_q  <= COL_W'(col_d);
			res_char_q <= res_char_d;
			res_attr_q <= res_attr_d;
			res_scr_q  <= res_scr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= screen_q[mem_raddr];
	end

	assign out_valid    = out_valid_q;
	assign res_row      = res_row_q;
	assign res_col      = res_col_q;
	assign res_char     = res_char_q;
	assign res_attr     = res_attr_q;
	assign res_scrolled = res_scr_q;

endmodule

### rtl/text_console_engine_core.sv
// Top level of the text console engine: attribute register, front end, queue, back end.
//
//  channel   direction  handshake               beat contents
//  in        input      in_valid / in_ready     mode, char_code, row, col
//  out       output     out_valid / out_ready   cursor_row, cursor_col, cell_char,
//                                               cell_attr, scrolled
//  cfg       input      cfg_wr_en (no wait)     cfg_wr_data -> char_attr
//
// The back end handles put char, newline, backspace and set cursor in its idle state;
// read cell waits on a registered memory read, a beat that scrolls blanks each cell
// of the recycled bottom row, and clear screen writes every cell through the one
// memory write port, one cell per cycle. Scrolling moves a top-row offset instead of
// copying rows. After reset a clearing pass zeroes the screen; in_ready stays low
// until it ends. A two-beat command queue lets the input side keep accepting while
// the back end sweeps or a result waits in the output register.
module text_console_engine_core import tce_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [7:0]       char_code,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] col,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ROW_W-1:0] cursor_row,
	output logic [COL_W-1:0] cursor_col,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,
	output logic             scrolled,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data
);

	logic [7:0] char_attr_q;
	logic       init_done;
	logic       fq_valid, fq_ready;
	cmd_t       fq_cmd;
	logic       bq_valid, bq_ready;
	cmd_t       bq_cmd;

	// Take attribute writes at once; the user must write only while the engine is idle, as this block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_attr_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			char_attr_q <= cfg_wr_data;
		end
	end

	// Decode and clamp each input beat; hold off until the clearing pass is done.
	tce_front #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_front (
		.accept_en (init_done),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.char_code (char_code),
		.row       (row),
		.col       (col),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_cmd     (fq_cmd)
	);

	// Buffer decoded commands so either side can stall on its own.
	tce_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_cmd    (bq_cmd)
	);

	// Execute commands against the cursor and screen memory; drive the result beat.
	tce_back #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (bq_valid),
		.cmd_ready    (bq_ready),
		.cmd          (bq_cmd),
		.char_attr    (char_attr_q),
		.init_done    (init_done),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res_row      (cursor_row),
		.res_col      (cursor_col),
		.res_char     (cell_char),
		.res_attr     (cell_attr),
		.res_scrolled (scrolled)
	);

	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !in_ready)
		else $error("input beat offered ready during clearing pass");

	a_cursor_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(cursor_row) <= ROWS - 1))
		else $error("cursor row beyond last screen row");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cursor_col == '0 && cursor_row == ROW_W'(ROWS - 1)))
		else $error("scroll left cursor away from start of last row");

endmodule
